// ----- src/msps_pkg.sv -----
// ----------------------------------------------------------------------------
// Saddle point search package
// Shared sizes and the packed transaction types of the search unit.
// ----------------------------------------------------------------------------
package msps_pkg;

  // Matrix store geometry
  localparam int MAX_ROWS = 8;
  localparam int MAX_COLS = 8;
  localparam int ROW_W    = 3;
  localparam int COL_W    = 3;
  localparam int ADDR_W   = ROW_W + COL_W;
  localparam int DEPTH    = MAX_ROWS * MAX_COLS;
  localparam int VAL_W    = 16;

  // Configuration register sizes
  localparam int DIM_W    = 4;
  localparam int CFG_IDX_W = 1;
  localparam int ORD_W    = 7;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROWS_IN_USE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_IN_USE = 1'b1;

  // Command codes
  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  // Input transaction
  typedef struct packed {
    logic                    cmd;
    logic [ROW_W-1:0]        elem_row;
    logic [COL_W-1:0]        elem_col;
    logic signed [VAL_W-1:0] elem_value;
  } in_t;

  // Result transaction
  typedef struct packed {
    logic             found;
    logic [ROW_W-1:0] point_row;
    logic [COL_W-1:0] point_col;
    logic [ORD_W-1:0] ordinal;
    logic             last;
  } out_t;

endpackage

// ----- src/matrix_saddle_point_search_unit.sv -----
// An element write is taken only while idle; a search of R x C elements runs a
// row minimum / column maximum pass, then a compare pass that reads and then
// compares each element, then flushes the last result (held while the output
// stalls). Both passes read the matrix store through its single read port.
// Throughput: one element write per cycle while idle; one search at a time.
// Reset: rows_in_use and cols_in_use go to 8; the matrix store is undefined.
// ----------------------------------------------------------------------------
// Matrix saddle point search unit
// Stores a signed matrix and reports every saddle point in row-major order.
// ----------------------------------------------------------------------------
module matrix_saddle_point_search_unit
  import msps_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_t                  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_t                 out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data
);

  // Sequencer state codes
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SCAN1 = 3'd1;
  localparam logic [2:0] ST_RD2   = 3'd2;
  localparam logic [2:0] ST_CMP2  = 3'd3;
  localparam logic [2:0] ST_FLUSH = 3'd4;

  logic [2:0]              state_r, state_nxt;
  logic [DIM_W-1:0]        cfg_rows_r, cfg_cols_r;
  logic [DIM_W-1:0]        nrows_r, nrows_nxt, ncols_r, ncols_nxt;
  logic [ROW_W-1:0]        scan_row_r, scan_row_nxt;
  logic [COL_W-1:0]        scan_col_r, scan_col_nxt;
  logic                    p1_v_r, p1_v_nxt;
  logic [ROW_W-1:0]        p1_row_r;
  logic [COL_W-1:0]        p1_col_r;
  logic signed [VAL_W-1:0] run_min_r;
  logic signed [VAL_W-1:0] p1_min;
  logic signed [VAL_W-1:0] row_min_r [MAX_ROWS];
  logic signed [VAL_W-1:0] col_max_r [MAX_COLS];
  logic                    pend_v_r, pend_v_nxt;
  logic [ROW_W-1:0]        pend_row_r, pend_row_nxt;
  logic [COL_W-1:0]        pend_col_r, pend_col_nxt;
  logic [ORD_W-1:0]        pend_ord_r, pend_ord_nxt;
  logic [ORD_W-1:0]        count_r, count_nxt;
  logic                    out_valid_r, out_valid_nxt;
  out_t                    out_data_r, out_data_nxt;

  // Matrix store
  logic signed [VAL_W-1:0] mem [DEPTH];
  logic                    mem_we, mem_re;
  logic [ADDR_W-1:0]       mem_waddr, mem_raddr;
  logic signed [VAL_W-1:0] rd_data_r;

  logic in_acc, out_free, last_col, last_row, saddle;
  logic [DIM_W-1:0] sat_rows, sat_cols;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || out_ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_rows_r <= DIM_W'(MAX_ROWS);
      cfg_cols_r <= DIM_W'(MAX_COLS);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROWS_IN_USE: cfg_rows_r <= cfg_data;
        REG_COLS_IN_USE: cfg_cols_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Active dimensions saturate at the store size
  assign sat_rows = (cfg_rows_r > DIM_W'(MAX_ROWS)) ? DIM_W'(MAX_ROWS) : cfg_rows_r;
  assign sat_cols = (cfg_cols_r > DIM_W'(MAX_COLS)) ? DIM_W'(MAX_COLS) : cfg_cols_r;

  // Store ports: writes only while idle, reads walk the scan counters
  assign mem_we    = in_acc && (in_data.cmd == CMD_WRITE);
  assign mem_waddr = {in_data.elem_row, in_data.elem_col};
  assign mem_re    = (state_r == ST_SCAN1) || (state_r == ST_RD2);
  assign mem_raddr = {scan_row_r, scan_col_r};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= in_data.elem_value;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_raddr];
    end
  end

  // Scan position
  assign last_col = ({1'b0, scan_col_r} == ncols_r - DIM_W'(1));
  assign last_row = ({1'b0, scan_row_r} == nrows_r - DIM_W'(1));

  // First pass: running row minimum and per-column maximum
  always_comb begin
    if (p1_col_r == '0 || rd_data_r < run_min_r) begin
      p1_min = rd_data_r;
    end else begin
      p1_min = run_min_r;
    end
  end

  always_ff @(posedge clk) begin
    if (p1_v_r) begin
      run_min_r <= p1_min;
      if ({1'b0, p1_col_r} == ncols_r - DIM_W'(1)) begin
        row_min_r[p1_row_r] <= p1_min;
      end
      if (p1_row_r == '0 || rd_data_r > col_max_r[p1_col_r]) begin
        col_max_r[p1_col_r] <= rd_data_r;
      end
    end
  end

  // Second pass compare
  assign saddle = (rd_data_r == row_min_r[scan_row_r]) &&
                  (rd_data_r == col_max_r[scan_col_r]);

  // Sequencer, pending report and output register
  always_comb begin
    state_nxt     = state_r;
    nrows_nxt     = nrows_r;
    ncols_nxt     = ncols_r;
    scan_row_nxt  = scan_row_r;
    scan_col_nxt  = scan_col_r;
    p1_v_nxt      = 1'b0;
    pend_v_nxt    = pend_v_r;
    pend_row_nxt  = pend_row_r;
    pend_col_nxt  = pend_col_r;
    pend_ord_nxt  = pend_ord_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;

    case (state_r)
      ST_IDLE: begin
        if (in_acc && in_data.cmd == CMD_SEARCH) begin
          nrows_nxt    = sat_rows;
          ncols_nxt    = sat_cols;
          scan_row_nxt = '0;
          scan_col_nxt = '0;
          pend_v_nxt   = 1'b0;
          count_nxt    = '0;
          if (sat_rows == '0 || sat_cols == '0) begin
            state_nxt = ST_FLUSH;
          end else begin
            state_nxt = ST_SCAN1;
          end
        end
      end

      ST_SCAN1: begin
        p1_v_nxt = 1'b1;
        if (last_col) begin
          scan_col_nxt = '0;
          if (last_row) begin
            scan_row_nxt = '0;
            state_nxt    = ST_RD2;
          end else begin
            scan_row_nxt = scan_row_r + ROW_W'(1);
          end
        end else begin
          scan_col_nxt = scan_col_r + COL_W'(1);
        end
      end

      ST_RD2: begin
        state_nxt = ST_CMP2;
      end

      ST_CMP2: begin
        if (!saddle || !pend_v_r || out_free) begin
          // A new saddle point releases the previous one as a non-final result
          if (saddle) begin
            if (pend_v_r) begin
              out_valid_nxt          = 1'b1;
              out_data_nxt.found     = 1'b1;
              out_data_nxt.point_row = pend_row_r;
              out_data_nxt.point_col = pend_col_r;
              out_data_nxt.ordinal   = pend_ord_r;
              out_data_nxt.last      = 1'b0;
            end
            pend_v_nxt   = 1'b1;
            pend_row_nxt = scan_row_r;
            pend_col_nxt = scan_col_r;
            pend_ord_nxt = count_r + ORD_W'(1);
            count_nxt    = count_r + ORD_W'(1);
          end
          if (last_col) begin
            scan_col_nxt = '0;
            if (last_row) begin
              state_nxt = ST_FLUSH;
            end else begin
              scan_row_nxt = scan_row_r + ROW_W'(1);
              state_nxt    = ST_RD2;
            end
          end else begin
            scan_col_nxt = scan_col_r + COL_W'(1);
            state_nxt    = ST_RD2;
          end
        end
      end

      ST_FLUSH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (pend_v_r) begin
            out_data_nxt.found     = 1'b1;
            out_data_nxt.point_row = pend_row_r;
            out_data_nxt.point_col = pend_col_r;
            out_data_nxt.ordinal   = pend_ord_r;
          end else begin
            out_data_nxt.found     = 1'b0;
            out_data_nxt.point_row = '0;
            out_data_nxt.point_col = '0;
            out_data_nxt.ordinal   = '0;
          end
          out_data_nxt.last = 1'b1;
          pend_v_nxt        = 1'b0;
          state_nxt         = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      p1_v_r      <= 1'b0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
      count_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      p1_v_r      <= p1_v_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
      count_r     <= count_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    nrows_r    <= nrows_nxt;
    ncols_r    <= ncols_nxt;
    scan_row_r <= scan_row_nxt;
    scan_col_r <= scan_col_nxt;
    p1_row_r   <= scan_row_r;
    p1_col_r   <= scan_col_r;
    pend_row_r <= pend_row_nxt;
    pend_col_r <= pend_col_nxt;
    pend_ord_r <= pend_ord_nxt;
    out_data_r <= out_data_nxt;
  end

  // A not-found result is always the final one and carries no running number.
  a_notfound_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r.found) |-> (out_data_r.last && out_data_r.ordinal == '0))
    else $error("not-found result without last mark");

  // A non-final saddle point report always trails the saddle point count.
  a_ordinal_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.found && !out_data_r.last) |->
    (out_data_r.ordinal != '0 && out_data_r.ordinal < count_r))
    else $error("result ordinal out of range");

  // The matrix store is never written while a search walks it.
  a_no_write_in_search: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !mem_we)
    else $error("store written during search");

  // A held report always has the latest running number.
  a_pending_ord: assert property (@(posedge clk) disable iff (!rst_n)
    pend_v_r |-> (pend_ord_r == count_r && count_r != '0))
    else $error("pending report out of step with count");

endmodule

// ----- verif/saddle_point_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Saddle point result checker
// Watches the element, result and register ports of the search unit. It keeps
// its own copy of the matrix and the active size. It works out the saddle
// points of every accepted search and compares each result transaction
// against the oldest one still waiting.
// ----------------------------------------------------------------------------
module saddle_point_checker
  import msps_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  in_t                  in_data,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  out_t                 out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data,
  output int                   mismatch_count,
  output int                   points_outstanding
);

  logic signed [VAL_W-1:0] grid [MAX_ROWS][MAX_COLS];
  logic [DIM_W-1:0]        rows_in_use_q;
  logic [DIM_W-1:0]        cols_in_use_q;
  out_t                    expected_points [$];
  int                      error_total;

  // Scan the active submatrix in row-major order and queue every element that
  // is a minimum of its row and a maximum of its column. Ties count.
  function automatic void find_saddle_points();
    out_t hits [DEPTH];
    out_t none_found;
    int   nr;
    int   nc;
    int   hit_count;
    bit   is_row_min;
    bit   is_col_max;
    nr = (rows_in_use_q > MAX_ROWS) ? MAX_ROWS : int'(rows_in_use_q);
    nc = (cols_in_use_q > MAX_COLS) ? MAX_COLS : int'(cols_in_use_q);
    hit_count = 0;
    for (int r = 0; r < nr; r++) begin
      for (int c = 0; c < nc; c++) begin
        is_row_min = 1'b1;
        is_col_max = 1'b1;
        for (int j = 0; j < nc; j++) begin
          if (grid[r][j] < grid[r][c]) is_row_min = 1'b0;
        end
        for (int i = 0; i < nr; i++) begin
          if (grid[i][c] > grid[r][c]) is_col_max = 1'b0;
        end
        if (is_row_min && is_col_max && hit_count < DEPTH) begin
          hits[hit_count].found     = 1'b1;
          hits[hit_count].point_row = r[ROW_W-1:0];
          hits[hit_count].point_col = c[COL_W-1:0];
          hits[hit_count].ordinal   = ORD_W'(hit_count + 1);
          hits[hit_count].last      = 1'b0;
          hit_count++;
        end
      end
    end
    // With no saddle point at all a single empty result closes the search.
    if (hit_count == 0) begin
      none_found       = '0;
      none_found.last  = 1'b1;
      expected_points.push_back(none_found);
    end else begin
      hits[hit_count-1].last = 1'b1;
      for (int k = 0; k < hit_count; k++) expected_points.push_back(hits[k]);
    end
  endfunction

  task automatic check_field(string field_name, logic [31:0] expected_value,
                             logic [31:0] actual_value);
    if (actual_value !== expected_value) begin
      $display("%0t: %s mismatch, expected %0d actual %0d",
               $time, field_name, expected_value, actual_value);
      error_total++;
    end
  endtask

  // All ports are sampled at the rising edge, before the block updates them.
  always @(posedge clk) begin
    if (!rst_n) begin
      rows_in_use_q = DIM_W'(MAX_ROWS);
      cols_in_use_q = DIM_W'(MAX_COLS);
      expected_points.delete();
      error_total = 0;
    end else begin
      // Register writes
      if (cfg_we) begin
        if (cfg_index == REG_ROWS_IN_USE) rows_in_use_q = cfg_data;
        else if (cfg_index == REG_COLS_IN_USE) cols_in_use_q = cfg_data;
      end

      // Result transaction against the oldest expectation
      if (out_valid && out_ready) begin
        if (expected_points.size() == 0) begin
          $display("%0t: result with none expected, expected none actual ",
                   $time, "found %0d row %0d col %0d ordinal %0d last %0d",
                   out_data.found, out_data.point_row, out_data.point_col,
                   out_data.ordinal, out_data.last);
          error_total++;
        end else begin
          out_t want;
          want = expected_points.pop_front();
          check_field("found", 32'(want.found), 32'(out_data.found));
          check_field("point_row", 32'(want.point_row), 32'(out_data.point_row));
          check_field("point_col", 32'(want.point_col), 32'(out_data.point_col));
          check_field("ordinal", 32'(want.ordinal), 32'(out_data.ordinal));
          check_field("last", 32'(want.last), 32'(out_data.last));
        end
      end

      // Element transaction: store a write or predict a search
      if (in_valid && in_ready) begin
        if (in_data.cmd == CMD_WRITE) begin
          grid[in_data.elem_row][in_data.elem_col] = in_data.elem_value;
        end else begin
          find_saddle_points();
        end
      end
    end
    mismatch_count     <= error_total;
    points_outstanding <= expected_points.size();
  end

endmodule

// ----- verif/matrix_saddle_point_search_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Saddle point search unit testbench
// Drives element writes and search commands at random pacing, changes the
// active matrix size between phases and leaves the checking to the checker.
// ----------------------------------------------------------------------------
module matrix_saddle_point_search_unit_tb;
  import msps_pkg::*;

  localparam int CYCLE_LIMIT   = 600000;
  localparam int SEGMENTS      = 12;
  localparam int SEG_ITEMS     = 21;
  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_CYCLES  = 16;
  localparam int IN_W          = $bits(in_t);

  // How element values are drawn while a phase fills the matrix
  typedef enum int {
    FILL_FULL,
    FILL_SMALL,
    FILL_EXTREME,
    FILL_TIES,
    FILL_RANKED
  } fill_style_e;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  in_t                  in_data;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_t                 out_data;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DIM_W-1:0]     cfg_data;

  int mismatch_count;
  int points_outstanding;
  int cycle_count = 0;
  int send_idle;
  int recv_idle;
  int rows_active;
  int cols_active;
  bit written [MAX_ROWS][MAX_COLS];

  matrix_saddle_point_search_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  saddle_point_checker point_check (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_data            (in_data),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_data           (out_data),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .mismatch_count     (mismatch_count),
    .points_outstanding (points_outstanding)
  );

  // Clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side back-pressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle);
  end

  // Cycle counter and watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("tb: failure");
    $finish;
  end

  function automatic logic signed [VAL_W-1:0] pick_value(fill_style_e style, int r);
    int v;
    case (style)
      FILL_SMALL:   v = int'($urandom_range(0, 2)) - 1;
      FILL_EXTREME: begin
        case ($urandom_range(0, 3))
          0:       v = -32768;
          1:       v = 32767;
          2:       v = -1;
          default: v = 0;
        endcase
      end
      FILL_TIES:    v = 7;
      // Rows ordered from large to small push the column maxima into row 0.
      FILL_RANKED:  v = (7 - r) * 100 + int'($urandom_range(0, 5));
      default:      v = int'($urandom);
    endcase
    return v[VAL_W-1:0];
  endfunction

  // Offer one element transaction after a random gap and wait for it to go.
  task automatic send_item(in_t item);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic write_elem(int r, int c, logic signed [VAL_W-1:0] v);
    in_t item;
    item.cmd        = CMD_WRITE;
    item.elem_row   = r[ROW_W-1:0];
    item.elem_col   = c[COL_W-1:0];
    item.elem_value = v;
    send_item(item);
    written[r][c] = 1'b1;
  endtask

  // Every active entry must hold a written value before a search reads it.
  task automatic run_search(fill_style_e style);
    in_t item;
    for (int r = 0; r < rows_active; r++) begin
      for (int c = 0; c < cols_active; c++) begin
        if (!written[r][c]) write_elem(r, c, pick_value(style, r));
      end
    end
    item            = in_t'(IN_W'($urandom));
    item.cmd        = CMD_SEARCH;
    send_item(item);
  endtask

  // Hold the sender until every expected result has come back.
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (points_outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_dims(int rows, int cols);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= REG_ROWS_IN_USE;
    cfg_data  <= rows[DIM_W-1:0];
    @(posedge clk);
    cfg_index <= REG_COLS_IN_USE;
    cfg_data  <= cols[DIM_W-1:0];
    @(posedge clk);
    cfg_we    <= 1'b0;
    rows_active = (rows > MAX_ROWS) ? MAX_ROWS : rows;
    cols_active = (cols > MAX_COLS) ? MAX_COLS : cols;
  endtask

  initial begin
    fill_style_e style;
    int          rows;
    int          cols;
    int          r;
    int          c;

    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    cfg_we      = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    send_idle   = 23;
    recv_idle   = 51;
    rows_active = MAX_ROWS;
    cols_active = MAX_COLS;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // A single element is always its own saddle point.
    set_dims(1, 1);
    write_elem(0, 0, -16'sd32768);
    run_search(FILL_FULL);

    // No active rows: the search reports nothing found.
    set_dims(0, 8);
    run_search(FILL_FULL);

    // Tied extremes give two saddle points in the top row.
    set_dims(2, 2);
    write_elem(0, 0, 16'sd32767);
    write_elem(0, 1, 16'sd32767);
    write_elem(1, 0, -16'sd32768);
    write_elem(1, 1, -16'sd32768);
    run_search(FILL_FULL);

    // A diagonal pattern has no saddle point.
    write_elem(0, 0, 16'sd1);
    write_elem(0, 1, 16'sd0);
    write_elem(1, 0, 16'sd0);
    write_elem(1, 1, 16'sd1);
    run_search(FILL_FULL);

    // One column: the largest element is the only saddle point.
    set_dims(8, 1);
    for (int k = 0; k < MAX_ROWS; k++) write_elem(k, 0, VAL_W'(k));
    run_search(FILL_FULL);

    // Random phases: each with its own size and fill style; pacing changes every four phases.
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      case (seg / 4)
        0:       begin send_idle = 23; recv_idle = 51; end
        1:       begin send_idle = 51; recv_idle = 23; end
        default: begin send_idle = 0;  recv_idle = 0;  end
      endcase
      case (seg)
        0:       begin rows = 8;  cols = 8;  end
        1:       begin rows = 15; cols = 12; end
        2:       begin rows = 1;  cols = 8;  end
        3:       begin rows = 8;  cols = 1;  end
        4:       begin rows = 5;  cols = 0;  end
        5:       begin rows = 9;  cols = 15; end
        default: begin
          rows = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 15))
                                             : int'($urandom_range(1, 8));
          cols = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 15))
                                             : int'($urandom_range(1, 8));
        end
      endcase
      set_dims(rows, cols);
      style = (seg == 0) ? FILL_TIES : fill_style_e'($urandom_range(0, 4));

      // Open with a search so every active entry not yet written is filled in this style.
      run_search(style);
      for (int n = 0; n < SEG_ITEMS; n++) begin
        if ($urandom_range(0, 9) == 0) begin
          run_search(style);
        end else begin
          if (rows_active > 0 && cols_active > 0 && $urandom_range(0, 9) < 7) begin
            r = $urandom_range(0, rows_active - 1);
            c = $urandom_range(0, cols_active - 1);
          end else begin
            r = $urandom_range(0, MAX_ROWS - 1);
            c = $urandom_range(0, MAX_COLS - 1);
          end
          if ($urandom_range(0, 9) < 6) write_elem(r, c, pick_value(style, r));
          else write_elem(r, c, pick_value(FILL_FULL, r));
        end
      end
      run_search(style);
    end

    // Drain and give the verdict.
    in_valid <= 1'b0;
    do @(posedge clk); while (points_outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
